// ===== src/wwsi_pkg.sv =====
// wwsi_pkg: shared types and constants of the whole-word string inclusion core.
// Holds command codes, controller states, datapath op codes and the
// command/status structs. Depends on nothing.
package wwsi_pkg;

   // default store depth in bytes
   localparam int unsigned MaxLenDefault = 256;

   // byte treated as word separator
   localparam logic [7:0] SPACE_BYTE = 8'h20;

   // request command codes
   typedef enum logic [1:0] {
      CMD_PATTERN = 2'd0,
      CMD_TEXT    = 2'd1,
      CMD_EVAL    = 2'd2
   } cmd_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_LEAD,
      S_TRIM,
      S_SCAN,
      S_TRY,
      S_TAIL,
      S_EMIT
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_APPEND,
      OP_START,
      OP_LEAD_STEP,
      OP_TRIM_INIT,
      OP_TRIM_STEP,
      OP_SCAN_INIT,
      OP_SCAN_SKIP,
      OP_TRY_INIT,
      OP_TRY_PSKIP,
      OP_TRY_TSKIP,
      OP_TRY_ADV,
      OP_TRY_FAIL,
      OP_TAIL_STEP,
      OP_RESULT
   } op_type;

   // controller -> datapath
   typedef struct packed {
      op_type op;
      logic   res_val;
      logic   load_rsp;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic p_lead_sp;  // pattern byte at read pointer is an in-range space
      logic t_lead_sp;  // text byte at read pointer is an in-range space
      logic p_empty;    // pattern read pointer at pattern count
      logic p_is_sp;    // pattern read byte is a space
      logic t_is_sp;    // text read byte is a space
      logic t_is_first; // text read byte equals first pattern byte
      logic bnd;        // text read pointer sits on a word boundary
      logic l3;         // pattern bytes remain in the compare window
      logic l4;         // text bytes remain
      logic y;          // previous pattern compare byte was a space
      logic z;          // previous text compare byte was a space
      logic bytes_eq;   // pattern and text read bytes equal
      logic rsp_free;   // output register can take a beat
   } dp_stat_type;

endpackage

// ===== src/wwsi_if.sv =====
// wwsi_if: valid/ready channel interfaces of the whole-word string inclusion core.
// Request channel carries a command and a byte, response channel one result bit.
// Depends on nothing.
interface wwsi_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface wwsi_rsp_if;
   logic valid;
   logic ready;
   logic included;

   modport source (output valid, output included, input ready);
   modport sink   (input valid, input included, output ready);
endinterface

// ===== src/wwsi_dp.sv =====
// wwsi_dp: datapath of the whole-word string inclusion core.
// Pattern and text stores, counts, pointers, compare flags and output register.
// Depends on wwsi_pkg.
module wwsi_dp #(
   parameter int unsigned MAX_LEN = wwsi_pkg::MaxLenDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_cmd,
   input  logic [7:0]           req_data_byte,
   input  wwsi_pkg::dp_cmd_type cmd,
   output wwsi_pkg::dp_stat_type stat,
   output logic                 rsp_valid,
   output logic                 rsp_included,
   input  logic                 rsp_ready
);
   import wwsi_pkg::*;

   localparam int unsigned AW = $clog2(MAX_LEN);
   localparam int unsigned CW = $clog2(MAX_LEN + 1);
   localparam logic [CW-1:0] LenMax = CW'(MAX_LEN);
   localparam logic [CW-1:0] One    = CW'(1);

   logic [7:0] pmem [MAX_LEN];
   logic [7:0] tmem [MAX_LEN];

   logic [CW-1:0] pcnt_ff, pcnt_in, tcnt_ff, tcnt_in;
   logic [CW-1:0] pa_ff, pa_in, ta_ff, ta_in;
   logic [CW-1:0] p_beg_ff, p_beg_in, p_end_ff, p_end_in, t_pos_ff, t_pos_in;
   logic [7:0]    p_first_ff, p_first_in;
   logic [7:0]    p_rd_ff, t_rd_ff;
   logic          bnd_ff, bnd_in, y_ff, y_in, z_ff, z_in, res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in, included_ff, included_in;
   logic          p_we, t_we;
   logic          p_is_sp, t_is_sp, l3, l4;

   // compare flags from registered read data and the pointers
   assign p_is_sp = (p_rd_ff == SPACE_BYTE);
   assign t_is_sp = (t_rd_ff == SPACE_BYTE);
   assign l3      = (pa_ff < p_end_ff);
   assign l4      = (ta_ff < tcnt_ff);

   always_comb begin
      stat.p_lead_sp  = (pa_ff < pcnt_ff) && p_is_sp;
      stat.t_lead_sp  = l4 && t_is_sp;
      stat.p_empty    = (pa_ff == pcnt_ff);
      stat.p_is_sp    = p_is_sp;
      stat.t_is_sp    = t_is_sp;
      stat.t_is_first = (t_rd_ff == p_first_ff);
      stat.bnd        = bnd_ff;
      stat.l3         = l3;
      stat.l4         = l4;
      stat.y          = y_ff;
      stat.z          = z_ff;
      stat.bytes_eq   = (p_rd_ff == t_rd_ff);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // next-state of pointers, counts and flags per op
   always_comb begin
      pcnt_in    = pcnt_ff;
      tcnt_in    = tcnt_ff;
      pa_in      = pa_ff;
      ta_in      = ta_ff;
      p_beg_in   = p_beg_ff;
      p_end_in   = p_end_ff;
      t_pos_in   = t_pos_ff;
      p_first_in = p_first_ff;
      bnd_in     = bnd_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      res_in     = res_ff;
      p_we       = 1'b0;
      t_we       = 1'b0;
      case (cmd.op)
         OP_APPEND: begin
            if (req_cmd == CMD_PATTERN && pcnt_ff < LenMax) begin
               p_we    = 1'b1;
               pcnt_in = pcnt_ff + One;
            end
            if (req_cmd == CMD_TEXT && tcnt_ff < LenMax) begin
               t_we    = 1'b1;
               tcnt_in = tcnt_ff + One;
            end
         end
         OP_START: begin
            pa_in = '0;
            ta_in = '0;
         end
         OP_LEAD_STEP: begin
            if (stat.p_lead_sp) pa_in = pa_ff + One;
            if (stat.t_lead_sp) ta_in = ta_ff + One;
         end
         OP_TRIM_INIT: begin
            p_beg_in   = pa_ff;
            t_pos_in   = ta_ff;
            p_first_in = p_rd_ff;
            p_end_in   = pcnt_ff;
            pa_in      = pcnt_ff - One;
         end
         OP_TRIM_STEP: begin
            p_end_in = pa_ff;
            pa_in    = pa_ff - One;
         end
         OP_SCAN_INIT: begin
            ta_in  = t_pos_ff;
            bnd_in = 1'b1;
         end
         OP_SCAN_SKIP: begin
            ta_in  = ta_ff + One;
            bnd_in = t_is_sp;
         end
         OP_TRY_INIT: begin
            t_pos_in = ta_ff;
            pa_in    = p_beg_ff;
            y_in     = 1'b0;
            z_in     = 1'b0;
         end
         OP_TRY_PSKIP: begin
            pa_in = pa_ff + One;
         end
         OP_TRY_TSKIP: begin
            ta_in = ta_ff + One;
            y_in  = p_is_sp;
         end
         OP_TRY_ADV: begin
            pa_in = pa_ff + One;
            ta_in = ta_ff + One;
            y_in  = p_is_sp;
            z_in  = t_is_sp;
         end
         OP_TRY_FAIL: begin
            // candidate byte is not a space, so the next byte is off-boundary
            ta_in  = t_pos_ff + One;
            bnd_in = 1'b0;
         end
         OP_TAIL_STEP: begin
            pa_in = pa_ff + One;
         end
         OP_RESULT: begin
            res_in = cmd.res_val;
         end
         default: begin
         end
      endcase
      if (cmd.load_rsp) begin
         pcnt_in = '0;
         tcnt_in = '0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      included_in  = included_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         included_in  = res_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_included = included_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff      <= '0;
         tcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pcnt_ff      <= pcnt_in;
         tcnt_ff      <= tcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pointer and payload registers
   always_ff @(posedge clock) begin
      pa_ff       <= pa_in;
      ta_ff       <= ta_in;
      p_beg_ff    <= p_beg_in;
      p_end_ff    <= p_end_in;
      t_pos_ff    <= t_pos_in;
      p_first_ff  <= p_first_in;
      bnd_ff      <= bnd_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      res_ff      <= res_in;
      included_ff <= included_in;
   end

   // byte stores: one write, one registered read at the next pointer
   always_ff @(posedge clock) begin
      if (p_we) pmem[pcnt_ff[AW-1:0]] <= req_data_byte;
      p_rd_ff <= pmem[pa_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (t_we) tmem[tcnt_ff[AW-1:0]] <= req_data_byte;
      t_rd_ff <= tmem[ta_in[AW-1:0]];
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= LenMax && tcnt_ff <= LenMax)
      else $error("store count beyond depth");

   a_clear_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (pcnt_ff == '0 && tcnt_ff == '0 && rsp_valid_ff))
      else $error("counts not cleared or response lost after result load");

   a_try_window: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_TRY_ADV |-> (l3 && l4 && stat.bytes_eq))
      else $error("compare advanced outside window or on mismatch");
`endif

endmodule

// ===== src/wwsi_ctrl.sv =====
// wwsi_ctrl: controller state machine of the whole-word string inclusion core.
// Sequences loading, leading skip, trim, candidate scan and compare.
// Depends on wwsi_pkg.
module wwsi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_cmd,
   output logic                  req_ready,
   input  wwsi_pkg::dp_stat_type stat,
   output wwsi_pkg::dp_cmd_type  cmd
);
   import wwsi_pkg::*;

   state_type state_ff, state_in;
   logic      req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath ops
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_IDLE;
      cmd.res_val  = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_PATTERN, CMD_TEXT: cmd.op = OP_APPEND;
                  CMD_EVAL: begin
                     cmd.op   = OP_START;
                     state_in = S_LEAD;
                  end
                  default: cmd.op = OP_IDLE;
               endcase
            end
         end
         // drop leading spaces of both strings in parallel
         S_LEAD: begin
            if (stat.p_lead_sp || stat.t_lead_sp) begin
               cmd.op = OP_LEAD_STEP;
            end else if (stat.p_empty || !stat.l4) begin
               cmd.op      = OP_RESULT;
               cmd.res_val = stat.p_empty && !stat.l4;
               state_in    = S_EMIT;
            end else begin
               cmd.op   = OP_TRIM_INIT;
               state_in = S_TRIM;
            end
         end
         // drop trailing spaces of the pattern
         S_TRIM: begin
            if (stat.p_is_sp) begin
               cmd.op = OP_TRIM_STEP;
            end else begin
               cmd.op   = OP_SCAN_INIT;
               state_in = S_SCAN;
            end
         end
         // look for a candidate start on a word boundary
         S_SCAN: begin
            if (!stat.l4) begin
               cmd.op      = OP_RESULT;
               cmd.res_val = 1'b0;
               state_in    = S_EMIT;
            end else if (!stat.t_is_first || !stat.bnd) begin
               cmd.op = OP_SCAN_SKIP;
            end else begin
               cmd.op   = OP_TRY_INIT;
               state_in = S_TRY;
            end
         end
         // space-collapsing compare from the candidate
         S_TRY: begin
            if (!stat.l3) begin
               // pattern used up: match only if text ends or a space follows
               if (!stat.l4 || stat.t_is_sp) begin
                  cmd.op      = OP_RESULT;
                  cmd.res_val = 1'b1;
                  state_in    = S_EMIT;
               end else begin
                  cmd.op   = OP_TRY_FAIL;
                  state_in = S_SCAN;
               end
            end else if (!stat.l4) begin
               state_in = S_TAIL;
            end else if (stat.p_is_sp && stat.y) begin
               cmd.op = OP_TRY_PSKIP;
            end else if (stat.t_is_sp && stat.z) begin
               cmd.op = OP_TRY_TSKIP;
            end else if (stat.bytes_eq) begin
               cmd.op = OP_TRY_ADV;
            end else begin
               cmd.op   = OP_TRY_FAIL;
               state_in = S_SCAN;
            end
         end
         // text used up: only spaces may remain in the pattern
         S_TAIL: begin
            if (stat.l3 && stat.p_is_sp) begin
               cmd.op = OP_TAIL_STEP;
            end else if (!stat.l3) begin
               cmd.op      = OP_RESULT;
               cmd.res_val = 1'b1;
               state_in    = S_EMIT;
            end else begin
               cmd.op   = OP_TRY_FAIL;
               state_in = S_SCAN;
            end
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.rsp_free)
      else $error("result loaded over a pending response beat");

   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_EVAL) |=> state_ff == S_LEAD)
      else $error("evaluate beat did not start the walk");

   a_append_in_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_APPEND |-> (req_fire && (req_cmd == CMD_PATTERN || req_cmd == CMD_TEXT)))
      else $error("store append without an accepted load beat");
`endif

endmodule

// ===== src/whole_word_string_inclusion_core.sv =====
// whole_word_string_inclusion_core: top level, checks whole-word inclusion of a pattern.
// Joins the controller and the datapath; depends on wwsi_pkg, wwsi_if,
// wwsi_ctrl and wwsi_dp.
//
//   channel  | dir | payload              | handshake
//   ---------+-----+----------------------+----------------------
//   req_ch   | in  | cmd[1:0], data_byte  | valid/ready, sink
//   rsp_ch   | out | included             | valid/ready, source
//
// Load beats (pattern or text byte) are taken back to back.
// An evaluate beat walks both stores through one read port each, one byte
// step per cycle: leading spaces, trailing pattern spaces, then the scan and
// compare steps; a string that is empty or all spaces ends the walk early.
// No request is taken during the walk; a new one is taken once the result
// sits in the output register, even while rsp_ch stalls.
// Reset is synchronous, clears counts, state and rsp valid; stores need none.
module whole_word_string_inclusion_core #(
   parameter int unsigned MAX_LEN = wwsi_pkg::MaxLenDefault
) (
   input  logic        clock,
   input  logic        reset,
   wwsi_req_if.sink    req_ch,
   wwsi_rsp_if.source  rsp_ch
);
   import wwsi_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   wwsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   wwsi_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_ch.cmd),
      .req_data_byte (req_ch.data_byte),
      .cmd           (dp_cmd),
      .stat          (dp_stat),
      .rsp_valid     (rsp_ch.valid),
      .rsp_included  (rsp_ch.included),
      .rsp_ready     (rsp_ch.ready)
   );

endmodule

// ===== bench/tb_whole_word_string_inclusion_core.sv =====
`timescale 1ns / 100ps
// tb_whole_word_string_inclusion_core: self-checking bench for the whole-word inclusion core.
// Queue-fed driver, scoreboard with a built-in predictor, random idling phases.
// Depends on wwsi_pkg, wwsi_if and whole_word_string_inclusion_core.
module tb_whole_word_string_inclusion_core;
   import wwsi_pkg::*;

   localparam int unsigned MAX_LEN      = MaxLenDefault;
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int unsigned HOLD_CYCLES  = 2000;
   localparam int unsigned PHASE_BEATS  = 240;
   localparam int unsigned DRAIN_CYCLES = 300;

   // command code the block leaves unused
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_B = 8'h62;
   localparam logic [7:0] CHAR_X = 8'h78;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data;
      logic       drain;  // hold this beat back until every result is in
   } beat_type;

   logic clock;
   logic reset;

   wwsi_req_if req_ch ();
   wwsi_rsp_if rsp_ch ();

   whole_word_string_inclusion_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // stimulus and scoreboard state
   beat_type    beat_q[$];
   logic        included_q[$];
   logic [7:0]  word_q[$];
   logic [7:0]  pat_q[$];
   logic [7:0]  txt_q[$];
   bit          offering;
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned beats_queued;
   int unsigned evals_taken;
   int unsigned results_taken;
   int unsigned holds_asked;
   int unsigned holds_done;
   int unsigned hold_left;
   int unsigned errors;
   int unsigned cycle_count;

   // predictor copy of the stores
   logic [7:0]  pat_mem [MAX_LEN];
   logic [7:0]  txt_mem [MAX_LEN];
   int unsigned pat_len;
   int unsigned txt_len;

   always #1 clock = ~clock;

   // compare from one candidate start, collapsing space runs
   // (pattern skip is checked before text skip)
   function automatic bit match_from(int unsigned p0, int unsigned plen,
                                     int unsigned t0, int unsigned tlen);
      int unsigned i3, l3, i4, l4, y, z;
      bit          differ;
      i3 = p0;
      l3 = plen;
      i4 = t0;
      l4 = tlen;
      y = 0;
      z = 0;
      differ = 1'b1;
      while (l3 > 0 && l4 > 0) begin
         if (pat_mem[i3] == SPACE_BYTE) begin
            if (y > 0) begin
               i3++;
               l3--;
               continue;
            end
            y++;
         end else begin
            y = 0;
         end
         if (txt_mem[i4] == SPACE_BYTE) begin
            if (z > 0) begin
               i4++;
               l4--;
               continue;
            end
            z++;
         end else begin
            z = 0;
         end
         differ = (pat_mem[i3] != txt_mem[i4]);
         i3++;
         i4++;
         if (differ) break;
         l3--;
         l4--;
      end
      if (differ) return 1'b0;
      if (l3 == 0) begin
         if (l4 == 0) return 1'b1;
         return txt_mem[i4] == SPACE_BYTE;
      end
      if (l4 == 0) begin
         while (l3 > 0 && pat_mem[i3] == SPACE_BYTE) begin
            i3++;
            l3--;
         end
         return l3 == 0;
      end
      return 1'b0;
   endfunction

   // whole-word inclusion of the loaded pattern in the loaded text
   function automatic bit word_included();
      int unsigned p0, plen, tp, tlen;
      p0 = 0;
      plen = pat_len;
      tp = 0;
      tlen = txt_len;
      while (plen > 0 && pat_mem[p0] == SPACE_BYTE) begin
         p0++;
         plen--;
      end
      while (tlen > 0 && txt_mem[tp] == SPACE_BYTE) begin
         tp++;
         tlen--;
      end
      if (plen == 0 && tlen == 0) return 1'b1;
      if (plen == 0 || tlen == 0) return 1'b0;
      while (plen > 0 && pat_mem[p0 + plen - 1] == SPACE_BYTE) plen--;
      while (plen > 0 && tlen > 0) begin
         while (tlen > 0 && txt_mem[tp] != pat_mem[p0]) begin
            tp++;
            tlen--;
         end
         if (tlen == 0) return 1'b0;
         // candidate must open the text or follow a space
         if (tp > 0 && txt_mem[tp - 1] != SPACE_BYTE) begin
            tp++;
            tlen--;
            continue;
         end
         if (match_from(p0, plen, tp, tlen)) return 1'b1;
         tp++;
         tlen--;
      end
      return 1'b0;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         offering = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.cmd == CMD_EVAL) evals_taken++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (beat_q.size() == 0 || $urandom_range(99) < idle_pct ||
                (beat_q[0].drain && evals_taken != results_taken)) begin
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid     <= 1'b1;
               req_ch.cmd       <= beat_q[0].cmd;
               req_ch.data_byte <= beat_q[0].data;
               void'(beat_q.pop_front());
               offering = 1'b1;
            end
         end
      end
   end

   // response receiver: random stalls plus requested long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         holds_done   <= holds_done + 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // scoreboard: check result beats first, then predict from request beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (included_q.size() == 0) begin
               $error("included: expected none, got %0b", rsp_ch.included);
               errors++;
            end else if (rsp_ch.included !== included_q[0]) begin
               $error("included: expected %0b, got %0b", included_q[0], rsp_ch.included);
               errors++;
            end
            if (included_q.size() != 0) void'(included_q.pop_front());
            results_taken <= results_taken + 1;
         end
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.cmd)
               CMD_PATTERN: begin
                  if (pat_len < MAX_LEN) begin
                     pat_mem[pat_len] = req_ch.data_byte;
                     pat_len++;
                  end
               end
               CMD_TEXT: begin
                  if (txt_len < MAX_LEN) begin
                     txt_mem[txt_len] = req_ch.data_byte;
                     txt_len++;
                  end
               end
               CMD_EVAL: begin
                  included_q.push_back(word_included());
                  pat_len = 0;
                  txt_len = 0;
               end
               default: ;  // spare code: no effect
            endcase
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_whole_word_string_inclusion_core: errors");
         $finish;
      end
   end

   task automatic push_beat(input logic [1:0] c, input logic [7:0] d, input bit w);
      beat_q.push_back('{cmd: c, data: d, drain: w});
      if (c != CMD_SPARE) beats_queued++;
   endtask

   // word-like byte: mostly a, b and spaces, now and then any byte
   function automatic logic [7:0] rand_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) return CHAR_A;
      if (r < 62) return CHAR_B;
      if (r < 92) return SPACE_BYTE;
      return 8'($urandom);
   endfunction

   task automatic fill_words(input int unsigned n);
      word_q.delete();
      repeat (n) word_q.push_back(rand_char());
   endtask

   // load pattern and text in random interleaving, then evaluate
   task automatic push_case(input bit w);
      int unsigned pi, ti;
      pi = 0;
      ti = 0;
      while (pi < pat_q.size() || ti < txt_q.size()) begin
         if (ti >= txt_q.size() || (pi < pat_q.size() && $urandom_range(1) == 1)) begin
            push_beat(CMD_PATTERN, pat_q[pi], 1'b0);
            pi++;
         end else begin
            push_beat(CMD_TEXT, txt_q[ti], 1'b0);
            ti++;
         end
         if ($urandom_range(49) == 0) push_beat(CMD_SPARE, 8'($urandom), 1'b0);
      end
      push_beat(CMD_EVAL, 8'($urandom), w);
   endtask

   // short text; pattern mostly cut from the text, sometimes at a word start
   task automatic random_case();
      int unsigned tl, pl, first, r, k;
      tl = $urandom_range(12);
      fill_words(tl);
      txt_q = word_q;
      r = $urandom_range(99);
      if (r < 55 && tl > 0) begin
         first = $urandom_range(tl - 1);
         if (r < 40) begin
            while (first > 0 && txt_q[first - 1] != SPACE_BYTE) first--;
         end
         pl = $urandom_range(tl - first, 1);
         pat_q.delete();
         for (k = 0; k < pl; k++) pat_q.push_back(txt_q[first + k]);
         if (r < 12) pat_q[$urandom_range(pl - 1)] = rand_char();
         if ($urandom_range(3) == 0) pat_q.push_front(SPACE_BYTE);
         if ($urandom_range(3) == 0) pat_q.push_back(SPACE_BYTE);
         if ($urandom_range(3) == 0) pat_q.insert($urandom_range(pat_q.size()), SPACE_BYTE);
      end else begin
         fill_words($urandom_range(6));
         pat_q = word_q;
      end
      push_case($urandom_range(24) == 0);
   endtask

   // lone evaluates, spare codes and broken sequences
   task automatic noise_case();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) begin
         push_beat(CMD_EVAL, 8'($urandom), 1'b0);
      end else if (r < 70) begin
         push_beat(CMD_SPARE, 8'($urandom), 1'b0);
      end else begin
         repeat ($urandom_range(4, 1)) push_beat(2'($urandom), 8'($urandom), 1'b0);
         push_beat(CMD_EVAL, 8'($urandom), 1'b0);
      end
   endtask

   // one or both stores filled to or past full
   task automatic big_case(input bit pat_full, input bit txt_full);
      fill_words(txt_full ? MAX_LEN + $urandom_range(4) : $urandom_range(8, 1));
      txt_q = word_q;
      if (pat_full && txt_full) begin
         pat_q = txt_q;
      end else begin
         fill_words(pat_full ? MAX_LEN + $urandom_range(4) : $urandom_range(3, 1));
         pat_q = word_q;
      end
      push_case(1'b0);
   endtask

   initial begin
      int unsigned ph, phase_start;
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_PATTERN;
      req_ch.data_byte = 8'h00;
      rsp_ch.ready     = 1'b0;
      offering         = 1'b0;
      idle_pct         = 0;
      stall_pct        = 0;
      beats_queued     = 0;
      evals_taken      = 0;
      results_taken    = 0;
      holds_asked      = 0;
      holds_done       = 0;
      hold_left        = 0;
      errors           = 0;
      cycle_count      = 0;
      pat_len          = 0;
      txt_len          = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // both empty
      push_beat(CMD_EVAL, 8'h00, 1'b0);
      // pattern of spaces only against empty text
      push_beat(CMD_PATTERN, SPACE_BYTE, 1'b0);
      push_beat(CMD_EVAL, 8'hFF, 1'b0);
      // pattern only
      push_beat(CMD_PATTERN, CHAR_A, 1'b0);
      push_beat(CMD_EVAL, 8'h00, 1'b0);
      // text only; sender waits for all results first
      push_beat(CMD_TEXT, CHAR_A, 1'b0);
      push_beat(CMD_EVAL, 8'h00, 1'b1);
      // extreme bytes, leading space in text, trailing space in pattern
      push_beat(CMD_TEXT, SPACE_BYTE, 1'b0);
      push_beat(CMD_TEXT, 8'h00, 1'b0);
      push_beat(CMD_TEXT, SPACE_BYTE, 1'b0);
      push_beat(CMD_TEXT, 8'hFF, 1'b0);
      push_beat(CMD_PATTERN, 8'hFF, 1'b0);
      push_beat(CMD_PATTERN, SPACE_BYTE, 1'b0);
      push_beat(CMD_EVAL, 8'hFF, 1'b0);
      // spare code
      push_beat(CMD_SPARE, 8'hFF, 1'b0);
      // match inside a word does not count
      push_beat(CMD_PATTERN, CHAR_A, 1'b0);
      push_beat(CMD_PATTERN, CHAR_B, 1'b0);
      push_beat(CMD_TEXT, CHAR_X, 1'b0);
      push_beat(CMD_TEXT, CHAR_A, 1'b0);
      push_beat(CMD_TEXT, CHAR_B, 1'b0);
      push_beat(CMD_EVAL, 8'h00, 1'b0);

      // random phases: none, sender idle, receiver stall, both
      for (ph = 0; ph < 4; ph++) begin
         while (beat_q.size() != 0 || offering) @(negedge clock);
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 60; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 60; end
            default: begin idle_pct = 23; stall_pct = 23; end
         endcase
         // long receiver hold-off while the sender keeps pushing
         if (ph == 0) holds_asked++;
         if (ph == 0) big_case(1'b0, 1'b1);
         if (ph == 1) big_case(1'b1, 1'b0);
         if (ph == 3) big_case(1'b1, 1'b1);
         phase_start = beats_queued;
         while (beats_queued - phase_start < PHASE_BEATS) begin
            if ($urandom_range(99) < 85) random_case();
            else noise_case();
         end
      end

      while (beat_q.size() != 0 || offering || included_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("tb_whole_word_string_inclusion_core: clean");
      end else begin
         $display("tb_whole_word_string_inclusion_core: errors");
      end
      $finish;
   end

endmodule
